// File: hw/rtl/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg
// Shared types and constants for the Ethernet/IPv4 receive classifier:
// protocol constants, verdict and drop reason codes, beat and result records.
// ----------------------------------------------------------------------------
package erc_pkg;

  // Default frame length limit; the byte counter saturates here
  localparam int MAX_FRAME_DEF = 2048;

  // Header geometry
  localparam int ETH_LEN    = 14;
  localparam int IP_HDR_LEN = 20;
  localparam int MAC_LEN    = 6;
  localparam int ETYPE_HI   = 12;
  localparam int ETYPE_LO   = 13;

  // Byte offsets inside the IPv4 header
  localparam logic [4:0] OFF_VER_IHL  = 5'd0;
  localparam logic [4:0] OFF_TOT_HI   = 5'd2;
  localparam logic [4:0] OFF_TOT_LO   = 5'd3;
  localparam logic [4:0] OFF_FRAG_HI  = 5'd6;
  localparam logic [4:0] OFF_PROTOCOL = 5'd9;

  // Protocol constants
  localparam logic [15:0] ETYPE_ARP   = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [3:0]  IPVERSION   = 4'd4;
  localparam logic [3:0]  IP_IHL_MIN  = 4'(IP_HDR_LEN / 4);
  localparam logic [15:0] IP_MF       = 16'h2000;
  localparam logic [15:0] CSUM_GOOD   = 16'hFFFF;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;

  typedef enum logic [1:0] {
    VERDICT_DROP      = 2'd0,
    VERDICT_ARP       = 2'd1,
    VERDICT_ICMP      = 2'd2,
    VERDICT_TRANSPORT = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    REASON_NONE      = 3'd0,
    REASON_SHORT_ETH = 3'd1,
    REASON_NOT_IP    = 3'd2,
    REASON_SHORT_IP  = 3'd3,
    REASON_CSUM      = 3'd4,
    REASON_UNSUPP    = 3'd5,
    REASON_TRUNC     = 3'd6,
    REASON_PROTOCOL  = 3'd7
  } reason_t;

  // One received byte with its sideband
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       csum_ok;
  } beat_t;

  // Classification result; verdict sits in the low bits
  typedef struct packed {
    logic [10:0] payload_length;
    logic [7:0]  ip_protocol;
    reason_t     drop_reason;
    verdict_t    verdict;
  } result_t;

endpackage

// File: hw/rtl/erc_in_stage.sv
// ----------------------------------------------------------------------------
// erc_in_stage
// Input register for frame bytes. Holds one beat and releases it to the
// parser unless it is a last byte whose result cannot yet be stored.
// ----------------------------------------------------------------------------
module erc_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  input  logic          in_tuser,
  input  logic          res_free,
  output logic          beat_take,
  output erc_pkg::beat_t beat
);
  import erc_pkg::*;

  logic  valid_r;
  beat_t beat_r;

  // Release the held beat when the result side has room for its verdict
  assign beat_take = valid_r && (!beat_r.last || res_free);
  assign in_tready = !valid_r || beat_take;
  assign beat      = beat_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (beat_take) begin
      valid_r <= 1'b0;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      beat_r.data    <= in_tdata;
      beat_r.last    <= in_tlast;
      beat_r.csum_ok <= in_tuser;
    end
  end

endmodule

// File: hw/rtl/erc_parser.sv
// ----------------------------------------------------------------------------
// erc_parser
// Per-frame header state and classification. Each released byte updates the
// Ethernet and IPv4 header fields and the running header checksum; on the
// last byte the verdict is formed from the updated fields and the state
// returns to its start-of-frame values.
// ----------------------------------------------------------------------------
module erc_parser #(
  parameter int MAX_FRAME = erc_pkg::MAX_FRAME_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [47:0]     cfg_wdata,
  input  logic            beat_take,
  input  erc_pkg::beat_t  beat,
  output erc_pkg::result_t result
);
  import erc_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  logic [47:0]      mac_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      etype_r, etype_nxt;
  logic             mac_match_r, mac_match_nxt;
  logic [7:0]       ver_ihl_r, ver_ihl_nxt;
  logic [7:0]       frag_r, frag_nxt;
  logic [15:0]      tot_len_r, tot_len_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [15:0]      csum_r, csum_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic             skip_r, skip_nxt;

  logic [7:0]       want;
  logic [4:0]       off;
  logic [16:0]      sum;
  logic [16:0]      tot_lim;

  // Parse the byte at the current position
  always_comb begin
    cnt_nxt       = cnt_r;
    etype_nxt     = etype_r;
    mac_match_nxt = mac_match_r;
    ver_ihl_nxt   = ver_ihl_r;
    frag_nxt      = frag_r;
    tot_len_nxt   = tot_len_r;
    proto_nxt     = proto_r;
    csum_nxt      = csum_r;
    hold_nxt      = hold_r;
    skip_nxt      = (cnt_r == '0) ? beat.csum_ok : skip_r;
    off           = 5'(cnt_r - CNT_W'(ETH_LEN));
    sum           = {1'b0, csum_r} + {1'b0, hold_r, beat.data};

    // Destination MAC byte, first on the wire is most significant
    case (cnt_r[2:0])
      3'd0:    want = mac_r[47:40];
      3'd1:    want = mac_r[39:32];
      3'd2:    want = mac_r[31:24];
      3'd3:    want = mac_r[23:16];
      3'd4:    want = mac_r[15:8];
      default: want = mac_r[7:0];
    endcase

    if (cnt_r < CNT_W'(MAX_FRAME)) begin
      cnt_nxt = cnt_r + CNT_W'(1);

      // Ethernet header
      if (cnt_r < CNT_W'(MAC_LEN)) begin
        if (want != beat.data) begin
          mac_match_nxt = 1'b0;
        end
      end else if (cnt_r == CNT_W'(ETYPE_HI)) begin
        etype_nxt = {beat.data, 8'h00};
      end else if (cnt_r == CNT_W'(ETYPE_LO)) begin
        etype_nxt = {etype_r[15:8], beat.data};
      end

      // IPv4 header: fields and ones'-complement sum with end-around carry
      if (cnt_r >= CNT_W'(ETH_LEN) && cnt_r < CNT_W'(ETH_LEN + IP_HDR_LEN)) begin
        if (!off[0]) begin
          hold_nxt = beat.data;
        end else begin
          csum_nxt = sum[15:0] + 16'(sum[16]);
        end
        case (off)
          OFF_VER_IHL:  ver_ihl_nxt = beat.data;
          OFF_TOT_HI:   tot_len_nxt = {beat.data, 8'h00};
          OFF_TOT_LO:   tot_len_nxt = {tot_len_r[15:8], beat.data};
          OFF_FRAG_HI:  frag_nxt    = beat.data;
          OFF_PROTOCOL: proto_nxt   = beat.data;
          default:      ;
        endcase
      end
    end
  end

  // Classify the frame from the updated header state
  always_comb begin
    result.verdict        = VERDICT_DROP;
    result.drop_reason    = REASON_NONE;
    result.ip_protocol    = '0;
    result.payload_length = '0;
    tot_lim               = 17'(cnt_nxt) - 17'(ETH_LEN);

    if (cnt_nxt < CNT_W'(ETH_LEN)) begin
      result.drop_reason = REASON_SHORT_ETH;
    end else if (etype_nxt == ETYPE_ARP) begin
      result.verdict = VERDICT_ARP;
    end else if (etype_nxt != ETYPE_IPV4 || !mac_match_nxt) begin
      result.drop_reason = REASON_NOT_IP;
    end else if (cnt_nxt < CNT_W'(ETH_LEN + IP_HDR_LEN)) begin
      result.drop_reason = REASON_SHORT_IP;
    end else begin
      result.ip_protocol = proto_nxt;
      if (!skip_nxt && csum_nxt != CSUM_GOOD) begin
        result.drop_reason = REASON_CSUM;
      end else if (ver_ihl_nxt[7:4] != IPVERSION || ver_ihl_nxt[3:0] != IP_IHL_MIN ||
                   (frag_nxt & IP_MF[15:8]) != 8'h00) begin
        result.drop_reason = REASON_UNSUPP;
      end else if (tot_len_nxt < 16'(IP_HDR_LEN) || {1'b0, tot_len_nxt} > tot_lim) begin
        // total length minus header must fit in the bytes after the header
        result.drop_reason = REASON_TRUNC;
      end else begin
        result.payload_length = 11'(tot_len_nxt - 16'(IP_HDR_LEN));
        if (proto_nxt == PROTO_ICMP) begin
          result.verdict = VERDICT_ICMP;
        end else if (proto_nxt == PROTO_UDP || proto_nxt == PROTO_TCP) begin
          result.verdict = VERDICT_TRANSPORT;
        end else begin
          result.drop_reason = REASON_PROTOCOL;
        end
      end
    end
  end

  // Station address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_r <= '0;
    end else if (cfg_we) begin
      mac_r <= cfg_wdata;
    end
  end

  // Frame state: advance per byte, clear after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (beat_take && beat.last)) begin
      cnt_r       <= '0;
      etype_r     <= '0;
      mac_match_r <= 1'b1;
      ver_ihl_r   <= '0;
      frag_r      <= '0;
      tot_len_r   <= '0;
      proto_r     <= '0;
      csum_r      <= '0;
      hold_r      <= '0;
      skip_r      <= 1'b0;
    end else if (beat_take) begin
      cnt_r       <= cnt_nxt;
      etype_r     <= etype_nxt;
      mac_match_r <= mac_match_nxt;
      ver_ihl_r   <= ver_ihl_nxt;
      frag_r      <= frag_nxt;
      tot_len_r   <= tot_len_nxt;
      proto_r     <= proto_nxt;
      csum_r      <= csum_nxt;
      hold_r      <= hold_nxt;
      skip_r      <= skip_nxt;
    end
  end

endmodule

// File: hw/rtl/erc_out_stage.sv
// ----------------------------------------------------------------------------
// erc_out_stage
// Result register. Loads one verdict per frame and holds it until the
// downstream side takes it.
// ----------------------------------------------------------------------------
module erc_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  erc_pkg::result_t result,
  output logic             res_free,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata
);
  import erc_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign res_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = res_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // Result capture
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

endmodule

// File: hw/rtl/eth_ipv4_rx_classifier.sv
// ----------------------------------------------------------------------------
// eth_ipv4_rx_classifier
// Receive-side Ethernet/IPv4 frame classifier: one verdict per frame.
//
//   channel  dir  beat content (low bit first)
//   in_*     in   tdata: data_byte; tlast: last_byte; tuser: csum_verified
//   out_*    out  tdata: verdict, drop_reason, ip_protocol, payload_length
//   cfg_*    in   wdata: station_mac, written when cfg_we is high
//
// One byte per clock cycle unless a last byte waits on a stalled result. The
// last byte of a frame passes from the input register through the header
// logic, which forms the result, into the result register.
// Synchronous active-low reset clears all frame state and station_mac.
// A stalled result holds up the input only when a further last byte is
// waiting; other bytes keep flowing.
// ----------------------------------------------------------------------------
module eth_ipv4_rx_classifier #(
  parameter int MAX_FRAME = erc_pkg::MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  input  logic        in_tuser,   // [0] csum_verified
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [1:0] verdict, [4:2] drop_reason,
                                  // [12:5] ip_protocol, [23:13] payload_length
  input  logic        cfg_we,
  input  logic [47:0] cfg_wdata
);
  import erc_pkg::*;

  logic    res_free;
  logic    beat_take;
  beat_t   beat;
  result_t result;

  // Input register
  erc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .res_free  (res_free),
    .beat_take (beat_take),
    .beat      (beat)
  );

  // Header parse and classification
  erc_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .beat_take (beat_take),
    .beat      (beat),
    .result    (result)
  );

  // Result register
  erc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (beat_take && beat.last),
    .result     (result),
    .res_free   (res_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: hw/rtl/erc_checker.sv
// ----------------------------------------------------------------------------
// erc_checker
// Port-level checks for the classifier: reset behavior, result hold under
// stall, and consistency between verdict, drop reason and reported fields.
// ----------------------------------------------------------------------------
module erc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  import erc_pkg::*;

  logic [1:0]  f_verdict;
  logic [2:0]  f_reason;
  logic [7:0]  f_proto;
  logic [10:0] f_plen;

  assign f_verdict = out_tdata[1:0];
  assign f_reason  = out_tdata[4:2];
  assign f_proto   = out_tdata[12:5];
  assign f_plen    = out_tdata[23:13];

  // No result in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A drop always carries a reason, an accepted frame never does
  a_reason: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid |-> ((f_verdict == VERDICT_DROP) == (f_reason != REASON_NONE)))
    else $error("verdict and drop reason disagree");

  // Frames dropped before the IPv4 header and ARP frames report no IP fields
  a_no_ip: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && (f_verdict == VERDICT_ARP || f_reason == REASON_SHORT_ETH ||
                     f_reason == REASON_NOT_IP || f_reason == REASON_SHORT_IP)
      |-> f_proto == 8'h00 && f_plen == 11'd0)
    else $error("IP fields reported for a non-IP verdict");

  // ICMP frames report protocol one
  a_icmp: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && f_verdict == VERDICT_ICMP |-> f_proto == PROTO_ICMP)
    else $error("ICMP verdict with another protocol");

endmodule

bind eth_ipv4_rx_classifier erc_checker u_erc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/sv/eth_ipv4_rx_classifier_test.sv
// ----------------------------------------------------------------------------
// eth_ipv4_rx_classifier_test
// Self-checking bench for the Ethernet/IPv4 receive classifier. A table of
// directed frames runs first, then random frames, most of them IPv4 with
// random content, some with broken headers, and the rest ARP and noise.
// Bytes go in with random gaps against random back-pressure, and each verdict
// beat is compared field by field with a fixed verdict or a byte-level parser model.
// ----------------------------------------------------------------------------
module eth_ipv4_rx_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  import erc_pkg::*;

  localparam int MAX_FRAME   = MAX_FRAME_DEF;
  localparam int IP_END      = ETH_LEN + IP_HDR_LEN;
  localparam int OFF_CSUM    = 10;
  localparam int IDLE_PCT    = 25;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;

  typedef enum {FR_RAW, FR_ARP, FR_IPV4} frame_kind_t;

  // One frame to send: shape of the headers plus an optional fixed verdict
  typedef struct {
    frame_kind_t kind;
    int          len;
    bit          mac_hit;
    logic [7:0]  ver_ihl;
    logic [7:0]  frag_hi;
    logic [7:0]  proto;
    logic [15:0] tot_len;
    logic [15:0] csum_xor;  // zero keeps the header checksum valid
    bit          hw_csum;
    bit          typed;
    result_t     want;
  } frame_row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic        cfg_we = 0;
  logic [47:0] cfg_wdata = '0;

  // Parser model state
  logic [47:0] station_mac_sh;
  int          seen_bytes;
  logic [15:0] seen_etype;
  bit          seen_mac_hit;
  logic [7:0]  seen_ver_ihl;
  logic [7:0]  seen_frag_hi;
  logic [7:0]  seen_proto;
  logic [7:0]  seen_hold;
  logic [15:0] seen_tot_len;
  logic [16:0] seen_sum;
  bit          seen_skip;

  result_t     verdict_q[$];
  logic [7:0]  frame_bytes[$];
  frame_row_t  directed_rows[$];
  int          fail_count = 0;
  bit          quiet = 0;
  bit          hold_req = 0;
  int          hold_left = 0;

  eth_ipv4_rx_classifier uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic result_t mk_result(verdict_t v, reason_t r, logic [7:0] p,
                                        logic [10:0] l);
    result_t res;
    res.verdict        = v;
    res.drop_reason    = r;
    res.ip_protocol    = p;
    res.payload_length = l;
    return res;
  endfunction

  function automatic void clear_frame_state();
    seen_bytes   = 0;
    seen_etype   = '0;
    seen_mac_hit = 1;
    seen_ver_ihl = '0;
    seen_frag_hi = '0;
    seen_proto   = '0;
    seen_hold    = '0;
    seen_tot_len = '0;
    seen_sum     = '0;
    seen_skip    = 0;
  endfunction

  // Advance the parser by one byte; on the last byte return 1 with the verdict
  function automatic bit classify_byte(logic [7:0] b, bit last, bit hw, output result_t res);
    int          off;
    int unsigned s;
    int          flen;
    res = '0;
    if (seen_bytes == 0) seen_skip = hw;
    // parse only below the saturation point of the byte counter
    if (seen_bytes < MAX_FRAME) begin
      if (seen_bytes < MAC_LEN) begin
        if (station_mac_sh[(5 - seen_bytes) * 8 +: 8] != b) seen_mac_hit = 0;
      end else if (seen_bytes == ETYPE_HI) begin
        seen_etype = {b, 8'h00};
      end else if (seen_bytes == ETYPE_LO) begin
        seen_etype[7:0] = b;
      end
      if (seen_bytes >= ETH_LEN && seen_bytes < IP_END) begin
        off = seen_bytes - ETH_LEN;
        // ones'-complement sum with end-around carry, one word per byte pair
        if (off % 2 == 0) begin
          seen_hold = b;
        end else begin
          s = seen_sum + {seen_hold, b};
          seen_sum = s[15:0] + s[16];
        end
        case (off)
          OFF_VER_IHL:  seen_ver_ihl = b;
          OFF_TOT_HI:   seen_tot_len[15:8] = b;
          OFF_TOT_LO:   seen_tot_len[7:0] = b;
          OFF_FRAG_HI:  seen_frag_hi = b;
          OFF_PROTOCOL: seen_proto = b;
          default: ;
        endcase
      end
      seen_bytes++;
    end
    if (!last) return 0;

    // checks in priority order
    flen = seen_bytes;
    if (flen < ETH_LEN) begin
      res.drop_reason = REASON_SHORT_ETH;
    end else if (seen_etype == ETYPE_ARP) begin
      res.verdict = VERDICT_ARP;
    end else if (seen_etype != ETYPE_IPV4 || !seen_mac_hit) begin
      res.drop_reason = REASON_NOT_IP;
    end else if (flen < IP_END) begin
      res.drop_reason = REASON_SHORT_IP;
    end else begin
      res.ip_protocol = seen_proto;
      if (!seen_skip && seen_sum != CSUM_GOOD) begin
        res.drop_reason = REASON_CSUM;
      end else if (seen_ver_ihl[7:4] != IPVERSION || seen_ver_ihl[3:0] != IP_IHL_MIN ||
                   (seen_frag_hi & IP_MF[15:8]) != 0) begin
        res.drop_reason = REASON_UNSUPP;
      end else if (seen_tot_len < IP_HDR_LEN ||
                   int'(seen_tot_len) - IP_HDR_LEN > flen - IP_END) begin
        res.drop_reason = REASON_TRUNC;
      end else begin
        res.payload_length = 11'(seen_tot_len - IP_HDR_LEN);
        if (seen_proto == PROTO_ICMP) res.verdict = VERDICT_ICMP;
        else if (seen_proto == PROTO_UDP || seen_proto == PROTO_TCP)
          res.verdict = VERDICT_TRANSPORT;
        else res.drop_reason = REASON_PROTOCOL;
      end
    end
    clear_frame_state();
    return 1;
  endfunction

  // Lay out the bytes of one frame in frame_bytes
  function automatic void build_frame(frame_row_t r);
    logic [7:0]  hdr[IP_HDR_LEN];
    int unsigned sum;
    logic [15:0] csum;
    int          spoil;
    frame_bytes.delete();
    // destination address, one byte spoiled on a miss
    spoil = $urandom_range(0, MAC_LEN - 1);
    for (int i = 0; i < MAC_LEN; i++) begin
      frame_bytes.push_back(station_mac_sh[(5 - i) * 8 +: 8] ^
                            ((!r.mac_hit && i == spoil) ? 8'($urandom_range(1, 255)) : 8'h00));
    end
    for (int i = 0; i < MAC_LEN; i++) frame_bytes.push_back(8'($urandom));
    case (r.kind)
      FR_IPV4: begin
        frame_bytes.push_back(ETYPE_IPV4[15:8]);
        frame_bytes.push_back(ETYPE_IPV4[7:0]);
      end
      FR_ARP: begin
        frame_bytes.push_back(ETYPE_ARP[15:8]);
        frame_bytes.push_back(ETYPE_ARP[7:0]);
      end
      default: begin
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
      end
    endcase
    // IPv4 header with random filler fields, checksum fixed up last
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    if (r.kind == FR_IPV4) begin
      hdr[OFF_VER_IHL]  = r.ver_ihl;
      hdr[OFF_TOT_HI]   = r.tot_len[15:8];
      hdr[OFF_TOT_LO]   = r.tot_len[7:0];
      hdr[OFF_FRAG_HI]  = r.frag_hi;
      hdr[OFF_PROTOCOL] = r.proto;
      hdr[OFF_CSUM]     = 8'h00;
      hdr[OFF_CSUM + 1] = 8'h00;
      sum = 0;
      for (int i = 0; i < IP_HDR_LEN; i += 2) sum += {hdr[i], hdr[i + 1]};
      sum = (sum & 32'hFFFF) + (sum >> 16);
      sum = (sum & 32'hFFFF) + (sum >> 16);
      csum = ~sum[15:0] ^ r.csum_xor;
      hdr[OFF_CSUM]     = csum[15:8];
      hdr[OFF_CSUM + 1] = csum[7:0];
    end
    foreach (hdr[i]) frame_bytes.push_back(hdr[i]);
    // pad with payload or cut back to the frame length
    while (frame_bytes.size() < r.len) frame_bytes.push_back(8'($urandom));
    while (frame_bytes.size() > r.len) void'(frame_bytes.pop_back());
  endfunction

  function automatic frame_row_t rand_row();
    frame_row_t r;
    int         pick;
    int         pay;
    pick = $urandom_range(99);
    if (pick < 72) r.kind = FR_IPV4;
    else if (pick < 84) r.kind = FR_ARP;
    else r.kind = FR_RAW;
    // mostly small frames, a few short ones and some longer ones
    pick = $urandom_range(99);
    if (pick < 11) r.len = $urandom_range(1, IP_END - 1);
    else if (pick < 19) r.len = $urandom_range(65, 200);
    else r.len = $urandom_range(IP_END, 64);
    r.mac_hit = $urandom_range(99) < 90;
    r.ver_ihl = ($urandom_range(99) < 85) ? 8'h45 : 8'($urandom);
    r.frag_hi = 8'($urandom);
    if ($urandom_range(99) < 80) r.frag_hi = r.frag_hi & ~IP_MF[15:8];
    case ($urandom_range(4))
      0:       r.proto = PROTO_ICMP;
      1:       r.proto = PROTO_TCP;
      2, 3:    r.proto = PROTO_UDP;
      default: r.proto = 8'($urandom);
    endcase
    // total length near the room the frame offers, sometimes past it or tiny
    pay = (r.len > IP_END) ? r.len - IP_END : 0;
    pick = $urandom_range(99);
    if (pick < 75) r.tot_len = 16'(IP_HDR_LEN + pay - $urandom_range(0, (pay < 6) ? pay : 6));
    else if (pick < 85) r.tot_len = 16'(IP_HDR_LEN + pay + $urandom_range(1, 4));
    else if (pick < 93) r.tot_len = 16'($urandom_range(0, IP_HDR_LEN + 4));
    else r.tot_len = 16'($urandom);
    r.csum_xor = ($urandom_range(99) < 88) ? 16'h0000 : 16'($urandom_range(1, 16'hFFFF));
    r.hw_csum  = $urandom_range(99) < 30;
    r.typed    = 0;
    r.want     = '0;
    return r;
  endfunction

  task automatic add_row(frame_kind_t k, int len, bit hit, logic [7:0] vi, logic [7:0] fh,
                         logic [7:0] pr, logic [15:0] tl, logic [15:0] cx, bit hw,
                         bit typed, result_t want);
    frame_row_t r;
    r.kind     = k;
    r.len      = len;
    r.mac_hit  = hit;
    r.ver_ihl  = vi;
    r.frag_hi  = fh;
    r.proto    = pr;
    r.tot_len  = tl;
    r.csum_xor = cx;
    r.hw_csum  = hw;
    r.typed    = typed;
    r.want     = want;
    directed_rows.push_back(r);
  endtask

  // Send one frame beat by beat and record its verdict
  task automatic send_frame(frame_row_t r);
    result_t res;
    bit      user;
    build_frame(r);
    foreach (frame_bytes[i]) begin
      // idle the input at random between beats unless quiet is set
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 0;
        @(posedge clk);
      end
      // only the first beat's flag is latched; the rest are noise
      user = (i == 0) ? r.hw_csum : 1'($urandom_range(1));
      in_tvalid <= 1;
      in_tdata  <= frame_bytes[i];
      in_tlast  <= (i == frame_bytes.size() - 1);
      in_tuser  <= user;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      if (classify_byte(frame_bytes[i], i == frame_bytes.size() - 1, user, res))
        verdict_q.push_back(r.typed ? r.want : res);
    end
  endtask

  task automatic run_random(int n);
    frame_row_t r;
    for (int k = 0; k < n; k++) begin
      r = rand_row();
      send_frame(r);
    end
  endtask

  // Hold the input until every verdict is out, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_station(logic [47:0] mac);
    drain();
    cfg_we    <= 1;
    cfg_wdata <= mac;
    @(posedge clk);
    cfg_we <= 0;
    station_mac_sh = mac;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Stimulus
  initial begin
    frame_row_t r;
    station_mac_sh = '0;
    clear_frame_state();

    // short frames, ARP winning over address and length, short IPv4
    add_row(FR_RAW, 1, 1, 8'h45, 8'h00, PROTO_UDP, 16'd20, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_SHORT_ETH, 8'd0, 11'd0));
    add_row(FR_RAW, 13, 1, 8'h45, 8'h00, PROTO_UDP, 16'd20, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_SHORT_ETH, 8'd0, 11'd0));
    add_row(FR_ARP, 14, 0, 8'h45, 8'h00, PROTO_UDP, 16'd20, 16'h0, 0, 1,
            mk_result(VERDICT_ARP, REASON_NONE, 8'd0, 11'd0));
    add_row(FR_IPV4, 14, 1, 8'h45, 8'h00, PROTO_UDP, 16'd20, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_SHORT_IP, 8'd0, 11'd0));
    add_row(FR_IPV4, 33, 1, 8'h45, 8'h00, PROTO_UDP, 16'd20, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_SHORT_IP, 8'd0, 11'd0));
    add_row(FR_IPV4, 34, 0, 8'h45, 8'h00, PROTO_UDP, 16'd46, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_NOT_IP, 8'd0, 11'd0));
    add_row(FR_RAW, 34, 1, 8'h45, 8'h00, PROTO_UDP, 16'd26, 16'h0, 0, 0, '0);
    // accepted protocols
    add_row(FR_IPV4, 34, 1, 8'h45, 8'h00, PROTO_ICMP, 16'd20, 16'h0, 0, 1,
            mk_result(VERDICT_ICMP, REASON_NONE, PROTO_ICMP, 11'd0));
    add_row(FR_IPV4, 44, 1, 8'h45, 8'h00, PROTO_UDP, 16'd30, 16'h0, 0, 1,
            mk_result(VERDICT_TRANSPORT, REASON_NONE, PROTO_UDP, 11'd10));
    add_row(FR_IPV4, 44, 1, 8'h45, 8'h00, PROTO_TCP, 16'd28, 16'h0, 0, 1,
            mk_result(VERDICT_TRANSPORT, REASON_NONE, PROTO_TCP, 11'd8));
    // bad checksum, caught and then skipped by the verified flag
    add_row(FR_IPV4, 34, 1, 8'h45, 8'h00, PROTO_UDP, 16'd26, 16'h1, 0, 1,
            mk_result(VERDICT_DROP, REASON_CSUM, PROTO_UDP, 11'd0));
    add_row(FR_IPV4, 40, 1, 8'h45, 8'h00, PROTO_UDP, 16'd26, 16'h1, 1, 1,
            mk_result(VERDICT_TRANSPORT, REASON_NONE, PROTO_UDP, 11'd6));
    // unsupported version, header length and fragments
    add_row(FR_IPV4, 34, 1, 8'h46, 8'h00, PROTO_UDP, 16'd26, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_UNSUPP, PROTO_UDP, 11'd0));
    add_row(FR_IPV4, 34, 1, 8'h65, 8'h00, PROTO_UDP, 16'd26, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_UNSUPP, PROTO_UDP, 11'd0));
    add_row(FR_IPV4, 34, 1, 8'hFF, 8'h00, PROTO_UDP, 16'd26, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_UNSUPP, PROTO_UDP, 11'd0));
    add_row(FR_IPV4, 34, 1, 8'h45, 8'h20, PROTO_UDP, 16'd26, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_UNSUPP, PROTO_UDP, 11'd0));
    add_row(FR_IPV4, 34, 1, 8'h45, 8'hDF, PROTO_UDP, 16'd26, 16'h0, 0, 0, '0);
    // small total length and truncated payloads
    add_row(FR_IPV4, 40, 1, 8'h45, 8'h00, PROTO_UDP, 16'd19, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_TRUNC, PROTO_UDP, 11'd0));
    add_row(FR_IPV4, 40, 1, 8'h45, 8'h00, PROTO_UDP, 16'd27, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_TRUNC, PROTO_UDP, 11'd0));
    add_row(FR_IPV4, 34, 1, 8'h45, 8'h00, PROTO_UDP, 16'hFFFF, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_TRUNC, PROTO_UDP, 11'd0));
    // unknown protocols, extremes of the field
    add_row(FR_IPV4, 40, 1, 8'h45, 8'h00, 8'hFF, 16'd26, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_PROTOCOL, 8'hFF, 11'd6));
    add_row(FR_IPV4, 40, 1, 8'h45, 8'h00, 8'h00, 16'd26, 16'h0, 0, 1,
            mk_result(VERDICT_DROP, REASON_PROTOCOL, 8'h00, 11'd6));

    repeat (7) @(posedge clk);
    rst_n <= 1;

    // directed frames against the reset station address
    foreach (directed_rows[i]) send_frame(directed_rows[i]);

    set_station('1);
    run_random(2);

    // stall the result side and flood tiny frames so the input backs up
    set_station(48'({$urandom, $urandom}));
    hold_req = 1;
    for (int k = 0; k < 8; k++) begin
      r = rand_row();
      r.len = $urandom_range(1, 4);
      send_frame(r);
    end
    drain();

    // back to back, no idling on either side
    quiet = 1;
    run_random(3);
    quiet = 0;

    set_station('0);
    run_random(2);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && verdict_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Result side: check each verdict beat and drive back-pressure
  initial begin
    result_t got;
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict beat, expected none, got %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          check_field("verdict", want.verdict, got.verdict);
          check_field("drop_reason", want.drop_reason, got.drop_reason);
          check_field("ip_protocol", want.ip_protocol, got.ip_protocol);
          check_field("payload_length", want.payload_length, got.payload_length);
        end
      end
      // long hold-off on request, random stalls otherwise
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 0;
      end
      out_tready <= (hold_left == 0) && (quiet || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stall = 0;
      else stall++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
